FILE: design/jfcf_pkg.sv
// Types, constants and CRC helper shared by the joystick failsafe command framer.
package jfcf_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_MSB    = 16'h8000;
	localparam logic [15:0] START_WORD = 16'hABCD;

	localparam logic signed [15:0] PCT_LIMIT = 16'sd100;

	localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd500;
	localparam logic [15:0] SEND_PERIOD_RESET  = 16'd20;
	localparam logic [15:0] AGE_MAX            = 16'hFFFF;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEND_PERIOD  = 1'b1;

	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic               command;
		logic signed [15:0] speed_percent;
		logic signed [15:0] steer_percent;
		logic [7:0]         packet_flags;
		logic [7:0]         packet_sequence;
		logic [15:0]        packet_crc;
	} item_t;

	typedef struct packed {
		logic signed [10:0] steer_units;
		logic signed [10:0] speed_units;
		logic [15:0]        frame_checksum;
		logic               link_alive;
	} frame_t;

	typedef struct packed {
		logic        emit;
		logic        alive;
		logic [15:0] held_speed;
		logic [15:0] held_steer;
	} frame_req_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/jfcf_crc_check.sv
// CRC-16/CCITT-FALSE check over the six packet bytes.
module jfcf_crc_check import jfcf_pkg::*; (
	input  item_t item,
	output logic  crc_ok
);

	logic [15:0] crc;

	always_comb begin
		crc = CRC_INIT;
		crc = crc_byte(crc, item.speed_percent[7:0]);
		crc = crc_byte(crc, item.speed_percent[15:8]);
		crc = crc_byte(crc, item.steer_percent[7:0]);
		crc = crc_byte(crc, item.steer_percent[15:8]);
		crc = crc_byte(crc, item.packet_flags);
		crc = crc_byte(crc, item.packet_sequence);
		crc_ok = (crc == item.packet_crc);
	end

endmodule

FILE: design/jfcf_link_state.sv
// Held joystick values, link age and send timer.
module jfcf_link_state import jfcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        advance,
	input  logic        crc_ok,
	input  logic [15:0] link_timeout,
	input  logic [15:0] send_period,
	output frame_req_t  req
);

	logic [15:0] held_speed_q;
	logic [15:0] held_steer_q;
	logic [15:0] link_age_q;
	logic [15:0] send_age_q;
	logic [15:0] link_age_next;
	logic [15:0] send_age_inc;
	logic        period_hit;

	always_comb begin
		if (link_age_q >= link_timeout) begin
			link_age_next = link_timeout;
		end else begin
			link_age_next = link_age_q + 16'd1;
		end
		if (send_age_q == AGE_MAX) begin
			send_age_inc = send_age_q;
		end else begin
			send_age_inc = send_age_q + 16'd1;
		end
		period_hit     = (send_age_inc >= send_period);
		req.emit       = (item.command == CMD_TICK) && period_hit;
		req.alive      = (link_age_next < link_timeout);
		req.held_speed = held_speed_q;
		req.held_steer = held_steer_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q <= '0;
			held_steer_q <= '0;
			link_age_q   <= '0;
			send_age_q   <= '0;
		end else if (advance) begin
			if (item.command == CMD_TICK) begin
				link_age_q <= link_age_next;
				send_age_q <= period_hit ? 16'd0 : send_age_inc;
			end else if (crc_ok) begin
				held_speed_q <= item.speed_percent;
				held_steer_q <= item.steer_percent;
				link_age_q   <= '0;
			end
		end
	end

endmodule

FILE: design/jfcf_frame_build.sv
// Motor command frame: clamp, scale and checksum; commands are zero on a dead link.
module jfcf_frame_build import jfcf_pkg::*; (
	input  frame_req_t req,
	output frame_t     frame
);

	function automatic logic signed [10:0] to_units(input logic signed [15:0] p);
		logic signed [15:0] c;
		logic [10:0]        n;
		if (p > PCT_LIMIT) begin
			c = PCT_LIMIT;
		end else if (p < -PCT_LIMIT) begin
			c = -PCT_LIMIT;
		end else begin
			c = p;
		end
		n = c[10:0];
		return {n[7:0], 3'b000} + {n[9:0], 1'b0};
	endfunction

	logic signed [10:0] su;
	logic signed [10:0] tu;

	always_comb begin
		if (req.alive) begin
			su = to_units(req.held_speed);
			tu = to_units(req.held_steer);
		end else begin
			su = '0;
			tu = '0;
		end
		frame.steer_units    = tu;
		frame.speed_units    = su;
		frame.frame_checksum = START_WORD ^ {{5{tu[10]}}, tu} ^ {{5{su[10]}}, su};
		frame.link_alive     = req.alive;
	end

endmodule

FILE: design/joystick_failsafe_command_framer.sv
// Top level of the joystick failsafe command framer.
//
//  channel | signals                        | direction
//  item    | item_valid item_ready item     | request in: packet or tick
//  frame   | frame_valid frame_ready frame  | request out: motor command frame
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write in
//
// One request per cycle unless a stalled frame blocks it: input register,
// one pass of CRC and counter logic, result register holding the frame.
// Reset sets timeout 500, period 20, ages and held values to zero.
// A stalled frame holds the input register only when the next tick emits.
module joystick_failsafe_command_framer import jfcf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   frame_valid,
	input  logic                   frame_ready,
	output frame_t                 frame,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic [15:0] link_timeout_q;
	logic [15:0] send_period_q;
	logic        crc_ok;
	logic        advance;
	logic        out_free;
	frame_req_t  req;
	frame_t      frame_next;
	logic        frame_valid_q;
	frame_t      frame_q;

	assign cfg_ready   = 1'b1;
	assign out_free    = !frame_valid_q || frame_ready;
	assign advance     = valid_s1 && (!req.emit || out_free);
	assign item_ready  = !valid_s1 || advance;
	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_timeout_q <= LINK_TIMEOUT_RESET;
			send_period_q  <= SEND_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				REG_SEND_PERIOD:  send_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	jfcf_crc_check u_crc (
		.item   (item_s1),
		.crc_ok (crc_ok)
	);

	jfcf_link_state u_link (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_s1),
		.advance      (advance),
		.crc_ok       (crc_ok),
		.link_timeout (link_timeout_q),
		.send_period  (send_period_q),
		.req          (req)
	);

	jfcf_frame_build u_build (
		.req   (req),
		.frame (frame_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (out_free) begin
			frame_valid_q <= advance && req.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req.emit) begin
			frame_q <= frame_next;
		end
	end

	a_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame.frame_checksum == (START_WORD
			^ {{5{frame.steer_units[10]}}, frame.steer_units}
			^ {{5{frame.speed_units[10]}}, frame.speed_units}))
		else $error("frame checksum does not match its commands");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame.link_alive |->
			frame.steer_units == 11'sd0 && frame.speed_units == 11'sd0)
		else $error("dead link frame carries nonzero commands");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled request");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> frame_valid && !frame_ready && req.emit)
		else $error("input register stalled without a blocked frame");

endmodule
